[src/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[src/rpeg_pkg.sv]
// Shared types and constants of the posture easing generator.
package rpeg_pkg;

  localparam logic [31:0] GOLDEN_SEED = 32'h9E3779B9;
  localparam int unsigned DIV_STEPS = 16;

  typedef enum logic [2:0] {
    REG_HOLD_MIN  = 3'd0,
    REG_HOLD_MAX  = 3'd1,
    REG_TRANS     = 3'd2,
    REG_ROLL_AMP  = 3'd3,
    REG_GAZE_AMP  = 3'd4,
    REG_ASYM_AMP  = 3'd5,
    REG_SEED      = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_RNG,
    OP_MUL_HOLD,
    OP_SET_HOLD,
    OP_TICK,
    OP_RECENTER,
    OP_START,
    OP_END,
    OP_MUL_TGT,
    OP_SET_TGT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_T2,
    OP_SET_T2,
    OP_MUL_EASE,
    OP_SET_EASE,
    OP_MUL_VAL,
    OP_SET_VAL,
    OP_COPY
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] ch;
    logic       take_in;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic moving;
    logic len_zero;
  } status_t;

endpackage

[src/rpeg_datapath.sv]
// Datapath: config registers, generator, clock, shared multiplier and divider.
module rpeg_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic [15:0]    in_tick,
  input  rpeg_pkg::cmd_t cmd,
  output rpeg_pkg::status_t status,
  output logic [63:0]    out_data,
  output logic           out_moving
);
  import rpeg_pkg::*;

  logic [19:0] hold_min, hold_max, trans_ms;
  logic [14:0] amp [3];
  logic [31:0] seed;

  logic [31:0] rng_word, clock_ms, pstart;
  logic [20:0] plen;
  logic        moving;
  logic [15:0] tick;
  logic signed [15:0] start_v [4];
  logic signed [15:0] goal_v [4];
  logic signed [15:0] now_v [4];
  logic [16:0] t, t2, ease;
  logic [20:0] rem;
  logic signed [45:0] prod;

  logic [31:0] elapsed, rng_next;
  logic [19:0] span;
  logic [14:0] amp_sel;
  logic [21:0] rem2;
  logic [17:0] three_m;
  logic signed [16:0] diff;
  logic signed [17:0] tgt;
  logic signed [24:0] mul_a;
  logic signed [20:0] mul_b;

  always_comb begin
    elapsed  = clock_ms - pstart;
    span     = (hold_max >= hold_min) ? (hold_max - hold_min) : 20'd0;
    rng_next = rng_word ^ (rng_word << 13);
    rng_next = rng_next ^ (rng_next >> 17);
    rng_next = rng_next ^ (rng_next << 5);
    unique case (cmd.ch)
      2'd0:    amp_sel = amp[0];
      2'd3:    amp_sel = amp[2];
      default: amp_sel = amp[1];
    endcase
    rem2    = {rem, 1'b0};
    three_m = 18'd196608 - {t, 1'b0};
    diff    = {goal_v[cmd.ch][15], goal_v[cmd.ch]} - {start_v[cmd.ch][15], start_v[cmd.ch]};
    tgt     = $signed({1'b0, prod[39:23]}) - $signed({3'b0, amp_sel});
    unique case (cmd.op)
      OP_MUL_HOLD: begin
        mul_a = $signed({1'b0, rng_word[31:8]});
        mul_b = $signed({1'b0, span});
      end
      OP_MUL_TGT: begin
        mul_a = $signed({1'b0, rng_word[31:8]});
        mul_b = $signed({6'b0, amp_sel});
      end
      OP_MUL_T2: begin
        mul_a = $signed({8'b0, t});
        mul_b = $signed({4'b0, t});
      end
      OP_MUL_EASE: begin
        mul_a = $signed({8'b0, t2});
        mul_b = $signed({3'b0, three_m});
      end
      OP_MUL_VAL: begin
        mul_a = {{8{diff[16]}}, diff};
        mul_b = $signed({4'b0, ease});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    status.ge       = elapsed >= {11'b0, plen};
    status.moving   = moving;
    status.len_zero = plen == 21'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_min <= 20'd2000;
      hold_max <= 20'd6000;
      trans_ms <= 20'd600;
      amp[0]   <= 15'd2560;
      amp[1]   <= 15'd1024;
      amp[2]   <= 15'd512;
      seed     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_MIN: hold_min <= cfg_data[19:0];
        REG_HOLD_MAX: hold_max <= cfg_data[19:0];
        REG_TRANS:    trans_ms <= cfg_data[19:0];
        REG_ROLL_AMP: amp[0]   <= cfg_data[14:0];
        REG_GAZE_AMP: amp[1]   <= cfg_data[14:0];
        REG_ASYM_AMP: amp[2]   <= cfg_data[14:0];
        REG_SEED:     seed     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.take_in) tick <= in_tick;
    if (cmd.load_out) begin
      out_data   <= {now_v[3], now_v[2], now_v[1], now_v[0]};
      out_moving <= moving;
    end
    unique case (cmd.op)
      OP_INIT: begin
        rng_word <= (seed != 32'd0) ? seed : GOLDEN_SEED;
        clock_ms <= '0;
        pstart   <= '0;
        moving   <= 1'b0;
        for (int i = 0; i < 4; i++) begin
          start_v[i] <= '0;
          goal_v[i]  <= '0;
          now_v[i]   <= '0;
        end
      end
      OP_RNG:      rng_word <= rng_next;
      OP_SET_HOLD: plen <= {1'b0, hold_min} + {1'b0, prod[43:24]};
      OP_TICK:     clock_ms <= clock_ms + {16'b0, tick};
      OP_RECENTER: begin
        moving <= 1'b0;
        pstart <= clock_ms;
        for (int i = 0; i < 4; i++) begin
          start_v[i] <= '0;
          goal_v[i]  <= '0;
          now_v[i]   <= '0;
        end
      end
      OP_START: begin
        for (int i = 0; i < 4; i++) start_v[i] <= now_v[i];
        moving <= 1'b1;
        plen   <= {1'b0, trans_ms};
        pstart <= clock_ms;
      end
      OP_END: begin
        moving <= 1'b0;
        pstart <= clock_ms;
      end
      OP_SET_TGT:  goal_v[cmd.ch] <= tgt[15:0];
      OP_DIV_INIT: begin
        rem <= elapsed[20:0];
        t   <= (plen == 21'd0) ? 17'h10000 : 17'd0;
      end
      OP_DIV_STEP: begin
        if (rem2 >= {1'b0, plen}) begin
          rem <= rem2[20:0] - plen;
          t   <= {t[15:0], 1'b1};
        end else begin
          rem <= rem2[20:0];
          t   <= {t[15:0], 1'b0};
        end
      end
      OP_SET_T2:   t2 <= prod[32:16];
      OP_SET_EASE: ease <= prod[32:16];
      OP_SET_VAL:  now_v[cmd.ch] <= start_v[cmd.ch] + prod[31:16];
      OP_COPY:     for (int i = 0; i < 4; i++) now_v[i] <= goal_v[i];
      default: ;
    endcase
  end

endmodule

[src/rpeg_ctrl.sv]
// Controller: sequences draws, division and easing multiplies per item.
`include "assert_macros.svh"
module rpeg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              in_action,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  rpeg_pkg::status_t status,
  output rpeg_pkg::cmd_t    cmd
);
  import rpeg_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_HRNG, S_HMUL, S_HSET, S_IDLE, S_REC, S_TICK, S_CHK, S_STRT,
    S_TRNG, S_TMUL, S_TSET, S_END, S_DINIT, S_DIV, S_MT2, S_ST2, S_MEASE,
    S_SEASE, S_VMUL, S_VSET, S_COPY, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] ch;
  logic [3:0] cnt;
  logic       ret_idle;
  logic       accept;
  logic       out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  always_comb begin
    cmd.ch       = ch;
    cmd.take_in  = accept;
    cmd.load_out = (state == S_OUT) && out_free;
    unique case (state)
      S_INIT:  cmd.op = OP_INIT;
      S_HRNG:  cmd.op = OP_RNG;
      S_HMUL:  cmd.op = OP_MUL_HOLD;
      S_HSET:  cmd.op = OP_SET_HOLD;
      S_REC:   cmd.op = OP_RECENTER;
      S_TICK:  cmd.op = OP_TICK;
      S_STRT:  cmd.op = OP_START;
      S_TRNG:  cmd.op = OP_RNG;
      S_TMUL:  cmd.op = OP_MUL_TGT;
      S_TSET:  cmd.op = OP_SET_TGT;
      S_END:   cmd.op = OP_END;
      S_DINIT: cmd.op = OP_DIV_INIT;
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_MT2:   cmd.op = OP_MUL_T2;
      S_ST2:   cmd.op = OP_SET_T2;
      S_MEASE: cmd.op = OP_MUL_EASE;
      S_SEASE: cmd.op = OP_SET_EASE;
      S_VMUL:  cmd.op = OP_MUL_VAL;
      S_VSET:  cmd.op = OP_SET_VAL;
      S_COPY:  cmd.op = OP_COPY;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      ret_idle <= 1'b1;
      ch       <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          ret_idle <= 1'b1;
          state    <= S_HRNG;
        end
        S_HRNG: state <= S_HMUL;
        S_HMUL: state <= S_HSET;
        S_HSET: state <= ret_idle ? S_IDLE : S_COPY;
        S_IDLE: begin
          if (cfg_we && cfg_index == REG_SEED) begin
            state <= S_INIT;
          end else if (accept) begin
            ret_idle <= 1'b0;
            state    <= in_action ? S_REC : S_TICK;
          end
        end
        S_REC:  state <= S_HRNG;
        S_TICK: state <= S_CHK;
        S_CHK: begin
          priority if (status.ge && !status.moving) state <= S_STRT;
          else if (status.ge) state <= S_END;
          else if (status.moving) state <= S_DINIT;
          else state <= S_COPY;
        end
        S_STRT: begin
          ch    <= '0;
          state <= S_TRNG;
        end
        S_TRNG: state <= S_TMUL;
        S_TMUL: state <= S_TSET;
        S_TSET: begin
          ch    <= ch + 2'd1;
          state <= (ch == 2'd3) ? S_DINIT : S_TRNG;
        end
        S_END:  state <= S_HRNG;
        S_DINIT: begin
          cnt   <= '0;
          state <= status.len_zero ? S_MT2 : S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(DIV_STEPS - 1)) state <= S_MT2;
        end
        S_MT2:   state <= S_ST2;
        S_ST2:   state <= S_MEASE;
        S_MEASE: state <= S_SEASE;
        S_SEASE: begin
          ch    <= '0;
          state <= S_VMUL;
        end
        S_VMUL: state <= S_VSET;
        S_VSET: begin
          ch    <= ch + 2'd1;
          state <= (ch == 2'd3) ? S_OUT : S_VMUL;
        end
        S_COPY: state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  `CHK_IMPLY(a_div_len, clk, rst, state == S_DIV, !status.len_zero)
  `CHK_NEXT(a_busy_after_in, clk, rst, accept, !s_tready)
  `CHK_IMPLY(a_load_free, clk, rst, cmd.load_out, out_free)

endmodule

[src/random_posture_easing_generator.sv]
// Top level of the random posture easing generator.
// Input channel s_*: one item per tick; s_tuser is the action (0 advance time
// by s_tdata ms, 1 recenter all channels). Output channel m_*: one item per
// input item carrying the four Q8.8 channel values and the transition flag.
// Config port: cfg_we with cfg_index/cfg_data writes one register per cycle;
// writing the seed while idle restarts the generator, clock and all values.
// Per item: in a hold phase the clock advances and the values are set to the
// targets; when a hold ends a transition starts with four target draws;
// inside a transition (and when one starts) a 16-step restoring divide gives
// the ratio, skipped for zero length, then six multiplies go through one
// shared multiplier; a transition end and a recenter draw a new hold length.
// One item is in work at a time; s_tready rises with m_tvalid, so a result
// waiting on m_tready does not block a new input.
// If the receiver stalls with a result still held, the block finishes the
// new item and then waits until the held result is taken.
// Reset: synchronous rst; after reset (and after a seed write while idle)
// the block draws its first hold length and s_tready stays low meanwhile.
module random_posture_easing_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tick_ms
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // roll_out, gaze_x_out, gaze_y_out, asym_out
  output logic        m_tuser,   // in_transition
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rpeg_pkg::*;

  cmd_t    cmd;
  status_t status;

  rpeg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_action (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rpeg_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tick    (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_data   (m_tdata),
    .out_moving (m_tuser)
  );

endmodule
